// ===== sv/chd_pkg.sv =====
package chd_pkg;

    localparam int MAX_SIZE_DIGITS_DEF = 8;
    localparam int CNT_W = 32;

    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    typedef enum logic [5:0] {
        PH_SIZE = 6'b000001,
        PH_EXT  = 6'b000010,
        PH_DATA = 6'b000100,
        PH_TRL1 = 6'b001000,
        PH_TRL2 = 6'b010000,
        PH_DONE = 6'b100000
    } t_phase;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic       bad_size;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_value(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.val = 4'(c - 8'h41 + 8'd10);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.val = 4'(c - 8'h61 + 8'd10);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

// ===== sv/chd_parse.sv =====
module chd_parse
    import chd_pkg::*;
#(
    parameter int MAX_SIZE_DIGITS = MAX_SIZE_DIGITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    input  logic       i_restart,
    output logic       o_res_valid,
    output t_result    o_res
);

    localparam int DcW = $clog2(MAX_SIZE_DIGITS + 1);

    t_phase           r_phase, n_phase, e_phase;
    logic [CNT_W-1:0] r_cnt, n_cnt, e_cnt;
    logic [DcW-1:0]   r_dc, n_dc, e_dc;
    logic             r_inv, n_inv, e_inv;
    t_hex             hx;

    always_comb begin
        // restart takes effect before this word is parsed
        if (i_restart) begin
            e_phase = PH_SIZE;
            e_cnt   = '0;
            e_dc    = '0;
            e_inv   = 1'b0;
        end else begin
            e_phase = r_phase;
            e_cnt   = r_cnt;
            e_dc    = r_dc;
            e_inv   = r_inv;
        end

        hx          = hex_value(i_byte);
        n_phase     = e_phase;
        n_cnt       = e_cnt;
        n_dc        = e_dc;
        n_inv       = e_inv;
        o_res_valid = 1'b0;
        o_res       = '{kind: KIND_DATA, data_byte: 8'd0, bad_size: 1'b0};

        case (e_phase)
            PH_SIZE, PH_EXT: begin
                if (i_byte == CH_LF) begin
                    if (e_inv || e_cnt == '0) begin
                        o_res_valid = 1'b1;
                        o_res       = '{kind: KIND_END, data_byte: 8'd0, bad_size: e_inv};
                        n_phase     = PH_DONE;
                    end else begin
                        n_dc    = '0;
                        n_inv   = 1'b0;
                        n_phase = PH_DATA;
                    end
                end else if (e_phase == PH_SIZE) begin
                    if (i_byte == CH_SEMI) begin
                        n_phase = PH_EXT;
                    end else if (i_byte != CH_CR) begin
                        if (!hx.ok) begin
                            n_inv = 1'b1;
                        end else if (e_dc >= DcW'(MAX_SIZE_DIGITS) || e_cnt[31:28] != 4'd0) begin
                            n_inv = 1'b1;
                        end else begin
                            n_dc  = e_dc + 1'b1;
                            n_cnt = {e_cnt[27:0], hx.val};
                        end
                    end
                end
            end
            PH_DATA: begin
                o_res_valid = 1'b1;
                o_res       = '{kind: KIND_DATA, data_byte: i_byte, bad_size: 1'b0};
                if (e_cnt != '0) begin
                    n_cnt = e_cnt - 1'b1;
                end
                // last byte of the chunk when count drops to zero
                if (e_cnt <= CNT_W'(1)) begin
                    n_phase = PH_TRL1;
                end
            end
            PH_TRL1: begin
                if (i_byte == CH_CR) begin
                    n_phase = PH_TRL2;
                end else begin
                    n_phase = PH_SIZE;
                    n_cnt   = '0;
                    n_dc    = '0;
                    n_inv   = 1'b0;
                end
            end
            PH_TRL2: begin
                n_phase = PH_SIZE;
                n_cnt   = '0;
                n_dc    = '0;
                n_inv   = 1'b0;
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIZE;
            r_cnt   <= '0;
            r_dc    <= '0;
            r_inv   <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_dc    <= n_dc;
            r_inv   <= n_inv;
        end
    end

endmodule

// ===== sv/chd_out.sv =====
module chd_out
    import chd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_result    i_res,
    input  logic       i_stall,
    output logic       o_free,
    output logic       o_valid,
    output logic       o_kind,
    output logic [7:0] o_data_byte,
    output logic       o_bad_size
);

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // payload holds while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid     = r_valid;
    assign o_kind      = r_res.kind;
    assign o_data_byte = r_res.data_byte;
    assign o_bad_size  = r_res.bad_size;

endmodule

// ===== sv/http_chunked_body_decoder_core.sv =====
// Chunked transfer body decoder.
// Input channel: i_valid / o_stall carry one body byte (i_in_byte) and a
// restart flag (i_restart) per word; restart drops back to a fresh size line
// before that byte is parsed. Output channel: o_valid / i_stall carry one
// result word: a data byte (o_kind 0) or the end of body (o_kind 1, with
// o_bad_size set when a size line was malformed or too long).
// One byte is accepted per cycle while o_stall is low. A byte lands in the input
// register at the accepting edge, is parsed there against the decoder state,
// and any result it makes is loaded into the output register when the parser
// advances; while the output register is busy the byte waits in the input register.
// Throughput is one byte per cycle while neither side stalls.
// Size lines, extensions, trailer bytes and everything after the end item
// give no result word and pass the parse stage even while the output is
// stalled; a data or end word waits there until the output register frees.
// Reset (synchronous, active low) empties both registers and leaves the
// decoder expecting a size line.
module http_chunked_body_decoder_core
    import chd_pkg::*;
#(
    parameter int MAX_SIZE_DIGITS = MAX_SIZE_DIGITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_restart,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_kind,
    output logic [7:0] o_data_byte,
    output logic       o_bad_size
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_restart;
    logic       res_valid;
    t_result    res;
    logic       out_free;
    logic       fire;

    // advance when the word makes no result or the output register can take it
    assign fire    = r_in_valid && (!res_valid || out_free);
    assign o_stall = r_in_valid && !fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte    <= i_in_byte;
            r_in_restart <= i_restart;
        end
    end

    chd_parse #(
        .MAX_SIZE_DIGITS(MAX_SIZE_DIGITS)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_byte      (r_in_byte),
        .i_restart   (r_in_restart),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    chd_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (fire && res_valid),
        .i_res       (res),
        .i_stall     (i_stall),
        .o_free      (out_free),
        .o_valid     (o_valid),
        .o_kind      (o_kind),
        .o_data_byte (o_data_byte),
        .o_bad_size  (o_bad_size)
    );

endmodule

// ===== sim/http_chunked_body_decoder_core_test.sv =====
module http_chunked_body_decoder_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import chd_pkg::*;

    localparam int          SIZE_DIGITS  = MAX_SIZE_DIGITS_DEF;
    localparam int unsigned HEX_RADIX    = 16;
    localparam int          RANDOM_WORDS = 850;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          REPORT_LIMIT = 10;
    localparam int          IDLE_MAX     = 7;

    class chunk_scoreboard;
        t_phase      phase;
        logic [31:0] chunk_left;
        int unsigned digits;
        bit          size_bad;
        t_result     expected_q[$];
        int          errors;
        int          data_words;
        int          end_words;
        int          bad_ends;

        function new();
            errors     = 0;
            data_words = 0;
            end_words  = 0;
            bad_ends   = 0;
            start_line();
        endfunction

        function void start_line();
            phase      = PH_SIZE;
            chunk_left = '0;
            digits     = 0;
            size_bad   = 1'b0;
        endfunction

        function int digit_value(input logic [7:0] c);
            if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
            if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
            if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
            return -1;
        endfunction

        // Line feed closes the size line: start data or end the body.
        function void close_size_line();
            t_result r;
            if (size_bad || chunk_left == 0) begin
                r.kind      = KIND_END;
                r.data_byte = '0;
                r.bad_size  = size_bad;
                expected_q.push_back(r);
                phase = PH_DONE;
            end else begin
                digits   = 0;
                size_bad = 1'b0;
                phase    = PH_DATA;
            end
        endfunction

        function void note_byte(input logic [7:0] b, input logic rs);
            int      v;
            t_result r;
            if (rs) start_line();
            case (phase)
                PH_SIZE: begin
                    if (b == CH_LF) begin
                        close_size_line();
                    end else if (b == CH_SEMI) begin
                        phase = PH_EXT;
                    end else if (b != CH_CR) begin
                        v = digit_value(b);
                        if (v < 0 || digits >= SIZE_DIGITS || chunk_left[31:28] != 0) begin
                            size_bad = 1'b1;
                        end else begin
                            digits++;
                            chunk_left = chunk_left * HEX_RADIX + v;
                        end
                    end
                end
                PH_EXT: begin
                    if (b == CH_LF) close_size_line();
                end
                PH_DATA: begin
                    r.kind      = KIND_DATA;
                    r.data_byte = b;
                    r.bad_size  = 1'b0;
                    expected_q.push_back(r);
                    if (chunk_left > 0) chunk_left--;
                    if (chunk_left == 0) phase = PH_TRL1;
                end
                PH_TRL1: begin
                    if (b == CH_CR) phase = PH_TRL2;
                    else start_line();
                end
                PH_TRL2: begin
                    start_line();
                end
                default: begin
                    phase = PH_DONE;
                end
            endcase
        endfunction

        function void check_word(input logic kind, input logic [7:0] db, input logic bad);
            t_result want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected word: kind %0d byte %02h bad_size %0d", kind, db, bad);
                return;
            end
            want = expected_q.pop_front();
            if (kind == KIND_END) begin
                end_words++;
                if (bad) bad_ends++;
            end else begin
                data_words++;
            end
            if (want.kind !== kind || want.data_byte !== db || want.bad_size !== bad) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("mismatch: expected kind %0d byte %02h bad_size %0d, got %0d %02h %0d",
                             want.kind, want.data_byte, want.bad_size, kind, db, bad);
            end
        endfunction
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic [7:0] i_in_byte   = 8'h00;
    logic       i_restart   = 1'b0;
    logic       i_stall     = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic       o_kind;
    logic [7:0] o_data_byte;
    logic       o_bad_size;

    chunk_scoreboard sb;
    int unsigned     src_gap_max    = 0;
    int unsigned     sink_stall_max = 0;
    int unsigned     stall_left     = 0;
    int              words_sent     = 0;

    http_chunked_body_decoder_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in_byte   (i_in_byte),
        .i_restart   (i_restart),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_kind      (o_kind),
        .o_data_byte (o_data_byte),
        .o_bad_size  (o_bad_size)
    );

    always #2 i_clk = ~i_clk;

    // Result side: check each accepted word, then hold stall for a random count.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                sb.check_word(o_kind, o_data_byte, o_bad_size);
                stall_left = $urandom_range(0, sink_stall_max);
            end
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic send_word(input logic [7:0] b, input logic rs);
        int unsigned gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        i_restart <= rs;
        do @(posedge i_clk); while (o_stall);
        sb.note_byte(b, rs);
        words_sent++;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 10) return 8'h30 + v;
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 8'd10;
    endfunction

    function automatic logic [7:0] bad_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (sb.digit_value(c) >= 0 || c == CH_CR || c == CH_LF || c == CH_SEMI);
        return c;
    endfunction

    // Size line of ndig digits (leading zeros allowed), stray carriage returns,
    // optional extension, optional carriage return, then line feed.
    task automatic send_size_line(input logic [31:0] chunk_len, input int ndig, input logic rs);
        logic       lead_rs;
        logic [7:0] c;
        lead_rs = rs;
        for (int k = ndig - 1; k >= 0; k--) begin
            if ($urandom_range(0, 9) == 0) begin
                send_word(CH_CR, lead_rs);
                lead_rs = 1'b0;
            end
            send_word(hex_char(chunk_len[4*k +: 4]), lead_rs);
            lead_rs = 1'b0;
        end
        if ($urandom_range(0, 4) == 0) begin
            send_word(CH_SEMI, lead_rs);
            lead_rs = 1'b0;
            repeat ($urandom_range(0, 4)) begin
                do c = 8'($urandom_range(0, 255)); while (c == CH_LF);
                send_word(c, 1'b0);
            end
        end
        if ($urandom_range(0, 1)) begin
            send_word(CH_CR, lead_rs);
            lead_rs = 1'b0;
        end
        send_word(CH_LF, lead_rs);
    endtask

    task automatic send_chunk(input int unsigned chunk_len, input logic rs);
        int         ndig;
        logic [7:0] c;
        ndig = 1;
        while ((chunk_len >> (4 * ndig)) != 0 && ndig < SIZE_DIGITS) ndig++;
        if ($urandom_range(0, 3) == 0) ndig = $urandom_range(ndig, SIZE_DIGITS);
        send_size_line(chunk_len, ndig, rs);
        repeat (chunk_len) send_word(8'($urandom_range(0, 255)), 1'b0);
        case ($urandom_range(0, 5))
            0: begin
                do c = 8'($urandom_range(0, 255)); while (c == CH_CR);
                send_word(c, 1'b0);
            end
            1: begin
                send_word(CH_CR, 1'b0);
                send_word(8'($urandom_range(0, 255)), 1'b0);
            end
            default: begin
                send_word(CH_CR, 1'b0);
                send_word(CH_LF, 1'b0);
            end
        endcase
    endtask

    task automatic send_body_end(input logic rs);
        logic lead_rs;
        lead_rs = rs;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: send_size_line(32'd0, $urandom_range(1, SIZE_DIGITS), rs);
            4, 5:       send_size_line(32'd0, 0, rs);
            6, 7: begin
                if ($urandom_range(0, 1)) begin
                    send_word(hex_char(4'($urandom_range(0, 15))), lead_rs);
                    lead_rs = 1'b0;
                end
                send_word(bad_char(), lead_rs);
                send_size_line($urandom, $urandom_range(0, 2), 1'b0);
            end
            default: begin
                // overflow the digit limit by one to three digits
                repeat ($urandom_range(1, 3)) begin
                    send_word(hex_char(4'($urandom_range(0, 15))), lead_rs);
                    lead_rs = 1'b0;
                end
                send_size_line($urandom, SIZE_DIGITS, 1'b0);
            end
        endcase
        repeat ($urandom_range(0, 6)) send_word(8'($urandom_range(0, 255)), 1'b0);
    endtask

    initial begin
        #2ms;
        $display("timeout: %0d words sent, %0d results still owed",
                 words_sent, sb.expected_q.size());
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        int   nchunks;
        logic lead_rs;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_gap_max    = IDLE_MAX;
        sink_stall_max = IDLE_MAX;

        // one-byte chunk, trailer of carriage return plus an arbitrary byte
        send_word(8'h31, 1'b0);
        send_word(CH_LF, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(CH_CR, 1'b0);
        send_word(8'h5A, 1'b0);
        // largest size, cut short by restart
        repeat (4) send_word(8'h46, 1'b0);
        repeat (4) send_word(8'h66, 1'b0);
        send_word(CH_LF, 1'b0);
        send_word(8'hFF, 1'b0);
        // zero size with extension, then a byte after the end
        send_word(8'h30, 1'b1);
        send_word(CH_SEMI, 1'b0);
        send_word(8'h78, 1'b0);
        send_word(CH_LF, 1'b0);
        send_word(8'h31, 1'b0);
        // one digit past the limit
        send_word(8'h30, 1'b1);
        repeat (SIZE_DIGITS - 1) send_word(8'h30, 1'b0);
        send_word(8'h31, 1'b0);
        send_word(CH_LF, 1'b0);
        // non-hex character
        send_word(8'h67, 1'b1);
        send_word(CH_LF, 1'b0);
        // empty size line
        send_word(CH_LF, 1'b1);

        while (words_sent < RANDOM_WORDS) begin
            case ($urandom_range(0, 3))
                0: begin src_gap_max = 0;        sink_stall_max = 0;        end
                1: begin src_gap_max = IDLE_MAX; sink_stall_max = 0;        end
                2: begin src_gap_max = 0;        sink_stall_max = IDLE_MAX; end
                default: begin src_gap_max = IDLE_MAX; sink_stall_max = IDLE_MAX; end
            endcase
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(4, 20))
                    send_word(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end else begin
                nchunks = $urandom_range(0, 4);
                lead_rs = 1'b1;
                repeat (nchunks) begin
                    send_chunk(($urandom_range(0, 7) == 0) ? $urandom_range(13, 80)
                                                          : $urandom_range(1, 12), lead_rs);
                    lead_rs = 1'b0;
                end
                // leave some bodies unterminated; the next one restarts
                if ($urandom_range(0, 9) != 0) send_body_end(lead_rs);
            end
        end
        i_valid <= 1'b0;

        while (sb.expected_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d input words giving %0d data words and %0d body ends (%0d bad size)",
                 words_sent, sb.data_words, sb.end_words, sb.bad_ends);
        $display("mismatches %0d, results still owed %0d", sb.errors, sb.expected_q.size());
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/chd_pkg.sv
sv/chd_parse.sv
sv/chd_out.sv
sv/http_chunked_body_decoder_core.sv
sim/http_chunked_body_decoder_core_test.sv
